// ----- design/acfp_pkg.sv -----
`timescale 1ns / 1ps

package acfp_pkg;

    localparam int TABLE_ROWS = 22;
    localparam int COUNT_W    = 7;
    localparam int POS_W      = 6;

    localparam logic [7:0]  SEP_BYTE   = 8'h2C;
    localparam logic [7:0]  PLUS_BYTE  = 8'h2B;
    localparam logic [7:0]  MINUS_BYTE = 8'h2D;
    localparam logic [7:0]  SPACE_BYTE = 8'h20;
    localparam logic [7:0]  TAB_BYTE   = 8'h09;
    localparam logic [7:0]  CR_BYTE    = 8'h0D;
    localparam logic [7:0]  ZERO_BYTE  = 8'h30;
    localparam logic [7:0]  NINE_BYTE  = 8'h39;
    localparam logic [31:0] MAG_LIMIT  = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        RK_INT  = 2'd0,
        RK_CHAR = 2'd1,
        RK_END  = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_TOO_LONG    = 2'd2
    } frame_status_t;

    typedef enum logic [1:0] {
        FK_ABSENT = 2'd0,
        FK_INT    = 2'd1,
        FK_STR    = 2'd2
    } field_kind_t;

    // number parser phases
    typedef enum logic [2:0] {
        NP_SKIP   = 3'b001,
        NP_DIGITS = 3'b010,
        NP_DONE   = 3'b100
    } number_phase_t;

    typedef struct packed {
        logic [31:0]   acc;
        number_phase_t phase;
        logic          neg;
    } num_state_t;

    localparam num_state_t NUM_CLEAR = '{acc: 32'd0, phase: NP_SKIP, neg: 1'b0};

    // bit 0 is position 2, bit 7 is position 9; row 0 is function id 1
    localparam logic [7:0] LAYOUT_INT [TABLE_ROWS] = '{
        8'h0F, 8'h0F, 8'h0F, 8'h3F, 8'h2F,
        8'h0F, 8'h0F, 8'h2F, 8'h0F, 8'h2F,
        8'h0F, 8'h00, 8'h00, 8'h0F, 8'h0F,
        8'h02, 8'h00, 8'hFF, 8'h0F, 8'h0F,
        8'h0F, 8'h0F
    };

    localparam logic [7:0] LAYOUT_STR [TABLE_ROWS] = '{
        8'h00, 8'h10, 8'h10, 8'h00, 8'h10,
        8'h00, 8'h00, 8'h10, 8'h00, 8'h10,
        8'h00, 8'h01, 8'h01, 8'h10, 8'h00,
        8'h01, 8'h01, 8'h00, 8'h10, 8'h10,
        8'h10, 8'h10
    };

    function automatic field_kind_t field_kind(input logic [POS_W-1:0] pos,
                                               input logic known,
                                               input logic [7:0] id);
        logic [4:0]  row;
        logic [2:0]  col;
        field_kind_t k;
        row = 5'(id - 8'd1);
        col = 3'(pos - 6'd2);
        k   = FK_ABSENT;
        if (pos < 6'd2) begin
            k = FK_INT;
        end
        else if (pos <= 6'd9 && known && id != 8'd0 && id <= 8'(TABLE_ROWS)) begin
            if (LAYOUT_INT[row][col]) begin
                k = FK_INT;
            end
            else if (LAYOUT_STR[row][col]) begin
                k = FK_STR;
            end
        end
        return k;
    endfunction

endpackage

// ----- design/acfp_atoi.sv -----
`timescale 1ns / 1ps

module acfp_atoi (
    input  acfp_pkg::num_state_t cur,
    input  logic [7:0]           data,
    output acfp_pkg::num_state_t nxt,
    output logic [31:0]          value
);
    import acfp_pkg::*;

    logic        is_digit;
    logic        is_space;
    logic        do_acc;
    logic [35:0] prod;
    logic [31:0] acc_acc;

    assign is_digit = (data >= ZERO_BYTE) && (data <= NINE_BYTE);
    assign is_space = (data == SPACE_BYTE) || ((data >= TAB_BYTE) && (data <= CR_BYTE));

    // acc * 10 + digit as shift-add, clamp magnitude at 2^31
    assign prod    = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
                   + {32'd0, 4'(data - ZERO_BYTE)};
    assign acc_acc = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];

    always_comb
    begin
        nxt    = cur;
        do_acc = 1'b0;
        unique case (cur.phase)
            NP_SKIP:
            begin
                if (is_space) begin
                    nxt = cur;
                end
                else if (data == PLUS_BYTE || data == MINUS_BYTE) begin
                    nxt.neg   = (data == MINUS_BYTE);
                    nxt.phase = NP_DIGITS;
                end
                else if (!is_digit) begin
                    nxt.phase = NP_DONE;
                end
                else begin
                    nxt.phase = NP_DIGITS;
                    do_acc    = 1'b1;
                end
            end
            NP_DIGITS:
            begin
                if (!is_digit) begin
                    nxt.phase = NP_DONE;
                end
                else begin
                    do_acc = 1'b1;
                end
            end
            NP_DONE:
            begin
                nxt = cur;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        if (do_acc) begin
            nxt.acc = acc_acc;
        end
    end

    // negate, or clamp the positive side to 2^31-1
    assign value = cur.neg ? (32'd0 - cur.acc) : (cur.acc[31] ? POS_LIMIT : cur.acc);

endmodule

// ----- design/ascii_csv_frame_parser.sv -----
`timescale 1ns / 1ps

// ASCII comma-separated frame parser.
// Input channel (in_valid / in_ready / rx_byte) carries one received byte per
// transfer. Bytes are dropped until head_byte opens a frame; the frame then
// runs to tail_byte, or is aborted with status "too long" when it reaches
// FRAME_MAX bytes counting the head. Fields 0 and 1 and table-marked integer
// fields yield their value when they close; string fields yield each byte.
// Output channel (out_valid / out_ready / result fields) carries at most one
// result per input byte, held in a single output register.
// Latency: a result appears on the outputs the cycle after its byte transfers.
// Throughput: one byte per cycle while in_ready is high; each byte is a
// single pass through the field decode and the shift-add digit accumulator.
// Stall: while a result waits and out_ready is low, in_ready drops; a new byte
// is taken in the same cycle that the waiting result transfers.
// Reset (rst_n low, asynchronous): outside any frame, output empty,
// head_byte = '$', tail_byte = '#'. Configuration writes (cfg_write,
// cfg_index, cfg_data) take effect at the next edge, with no read-back.

module ascii_csv_frame_parser #(
    parameter int FRAME_MAX = 64,
    parameter int ID_COUNT  = 22
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [7:0]              cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              rx_byte,

    output logic                    out_valid,
    input  logic                    out_ready,
    output acfp_pkg::result_kind_t  result_kind,
    output logic [5:0]              field_position,
    output logic signed [31:0]      int_value,
    output logic [7:0]              char_byte,
    output logic                    frame_end,
    output acfp_pkg::frame_status_t frame_status,
    output logic [7:0]              function_id
);
    import acfp_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(FRAME_MAX);
    localparam logic [7:0]         ID_LIMIT  = 8'(ID_COUNT);
    localparam logic [0:0]         REG_HEAD  = 1'b0;
    localparam logic [0:0]         REG_TAIL  = 1'b1;

    // configuration
    logic [7:0] head_reg;
    logic [7:0] tail_reg;

    // frame state
    logic               in_frame_reg,  in_frame_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [POS_W-1:0]   field_reg,     field_next;
    num_state_t         num_reg,       num_next;
    logic [7:0]         id_reg,        id_next;
    logic               known_reg,     known_next;

    // output register
    logic          out_valid_reg;
    result_kind_t  kind_reg,   kind_next;
    logic [5:0]    pos_reg;
    logic [31:0]   value_reg,  value_next;
    logic [7:0]    char_reg,   char_next;
    logic          end_reg,    end_next;
    frame_status_t status_reg, status_next;
    logic [7:0]    fid_reg;

    logic               accept;
    logic               emit;
    num_state_t         num_fed;
    logic [31:0]        num_value;
    logic [COUNT_W-1:0] count_inc;
    field_kind_t        kind_now;
    logic [7:0]         id_closed;
    logic               known_closed;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    acfp_atoi u_atoi (
        .cur   (num_reg),
        .data  (rx_byte),
        .nxt   (num_fed),
        .value (num_value)
    );

    assign count_inc = count_reg + COUNT_W'(1);
    assign kind_now  = field_kind(field_reg, known_reg, id_reg);

    // closing field 1 latches the function id
    always_comb
    begin
        id_closed    = id_reg;
        known_closed = known_reg;
        if (field_reg == 6'd1) begin
            id_closed    = num_value[7:0];
            known_closed = (num_value[7:0] != 8'd0) && (num_value[7:0] <= ID_LIMIT);
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        field_next    = field_reg;
        num_next      = num_reg;
        id_next       = id_reg;
        known_next    = known_reg;
        emit          = 1'b0;
        kind_next     = RK_END;
        value_next    = 32'd0;
        char_next     = 8'd0;
        end_next      = 1'b0;
        status_next   = ST_OK;

        if (!in_frame_reg) begin
            // wait for the head; drop everything else
            if (rx_byte == head_reg) begin
                in_frame_next = 1'b1;
                count_next    = COUNT_W'(1);
                field_next    = '0;
                num_next      = NUM_CLEAR;
                id_next       = 8'd0;
                known_next    = 1'b0;
            end
        end
        else if (rx_byte == tail_reg) begin
            // tail wins over the length check and the separator
            emit          = 1'b1;
            end_next      = 1'b1;
            status_next   = known_closed ? ST_OK : ST_UNSUPPORTED;
            id_next       = id_closed;
            known_next    = known_closed;
            in_frame_next = 1'b0;
            count_next    = '0;
            num_next      = NUM_CLEAR;
            if (kind_now == FK_INT) begin
                kind_next  = RK_INT;
                value_next = num_value;
            end
        end
        else if (count_inc >= COUNT_MAX) begin
            // abort an overlong frame
            emit          = 1'b1;
            end_next      = 1'b1;
            status_next   = ST_TOO_LONG;
            in_frame_next = 1'b0;
            count_next    = '0;
            num_next      = NUM_CLEAR;
        end
        else if (rx_byte == SEP_BYTE) begin
            count_next = count_inc;
            id_next    = id_closed;
            known_next = known_closed;
            num_next   = NUM_CLEAR;
            if (field_reg != 6'd63) begin
                field_next = field_reg + 6'd1;
            end
            if (kind_now == FK_INT) begin
                emit       = 1'b1;
                kind_next  = RK_INT;
                value_next = num_value;
            end
        end
        else begin
            count_next = count_inc;
            case (kind_now)
                FK_INT:
                begin
                    num_next = num_fed;
                end
                FK_STR:
                begin
                    emit      = 1'b1;
                    kind_next = RK_CHAR;
                    char_next = rx_byte;
                end
                default:
                begin
                    num_next = num_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg <= 8'h24;
            tail_reg <= 8'h23;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                REG_HEAD: head_reg <= cfg_data;
                REG_TAIL: tail_reg <= cfg_data;
                default:  head_reg <= head_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            field_reg    <= '0;
            num_reg      <= NUM_CLEAR;
            id_reg       <= 8'd0;
            known_reg    <= 1'b0;
        end
        else if (accept) begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            field_reg    <= field_next;
            num_reg      <= num_next;
            id_reg       <= id_next;
            known_reg    <= known_next;
        end
    end

    // load a new result on transfer, drop the old one once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit) begin
            kind_reg   <= kind_next;
            pos_reg    <= field_reg;
            value_reg  <= value_next;
            char_reg   <= char_next;
            end_reg    <= end_next;
            status_reg <= status_next;
            fid_reg    <= id_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign field_position = pos_reg;
    assign int_value      = signed'(value_reg);
    assign char_byte      = char_reg;
    assign frame_end      = end_reg;
    assign frame_status   = status_reg;
    assign function_id    = fid_reg;

`ifndef SYNTHESIS
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> count_reg == '0)
        else $error("byte count nonzero outside a frame");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < COUNT_MAX)
        else $error("byte count reached frame limit");

    a_tail_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_frame_reg && rx_byte == tail_reg
        |=> out_valid_reg && end_reg && !in_frame_reg)
        else $error("tail did not close the frame");

    a_status_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !end_reg |-> status_reg == ST_OK && kind_reg != RK_END)
        else $error("mid-frame result with end status");
`endif

endmodule
